// ===== rtl/tap_tempo_estimator_assert.svh =====
// Assertion macros for the tap tempo estimator.
// Included by the top level; no other dependencies.
`ifndef TAP_TEMPO_ESTIMATOR_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tte_pkg.sv =====
// Shared types, codes and the microcode table of the tap tempo estimator.
// No dependencies; used by tte_divider, tap_tempo_estimator and the testbench.
package tte_pkg;

    localparam int CNT_W     = 4;
    localparam int FRAC_BITS = 8;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // Sixty million microseconds times one hundred, with eight fraction bits.
    localparam logic [63:0] CENTI_MINUTE_Q8 = 64'd6000000000 << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'd1;

    localparam logic [2:0] ST_ARMED   = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_FAST    = 3'd2;
    localparam logic [2:0] ST_OUTLIER = 3'd3;
    localparam logic [2:0] ST_ACCEPT  = 3'd4;
    localparam logic [2:0] ST_CLEAR   = 3'd5;

    typedef struct packed {
        logic        operation;
        logic [31:0] tap_time_us;
    } in_item_t;

    typedef struct packed {
        logic        bpm_valid;
        logic [15:0] bpm_centi;
        logic [2:0]  tap_status;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_GAP,
        OP_DIV_MEAN,
        OP_DIV_STEP,
        OP_MEAN_UPD,
        OP_DIV_BPM,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_CLEAR,
        C_NOT_ARMED,
        C_TIMEOUT,
        C_FAST,
        C_OUTLIER,
        C_MORE,
        C_MEAN_ZERO
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              wait_out;
        logic              valid;
        logic [2:0]        status;
        logic              set_last;
        logic              clr_mean;
        logic              set_armed;
        logic              clr_armed;
    } ucode_t;

    localparam logic [STEP_W-1:0] A_FETCH     = 5'd0;
    localparam logic [STEP_W-1:0] A_CLASSIFY  = 5'd1;
    localparam logic [STEP_W-1:0] A_ARMCHK    = 5'd2;
    localparam logic [STEP_W-1:0] A_TOUTCHK   = 5'd3;
    localparam logic [STEP_W-1:0] A_FASTCHK   = 5'd4;
    localparam logic [STEP_W-1:0] A_OUTCHK    = 5'd5;
    localparam logic [STEP_W-1:0] A_MEAN_LD   = 5'd6;
    localparam logic [STEP_W-1:0] A_MEAN_DIV  = 5'd7;
    localparam logic [STEP_W-1:0] A_MEAN_UPD  = 5'd8;
    localparam logic [STEP_W-1:0] A_BPM_LD    = 5'd9;
    localparam logic [STEP_W-1:0] A_BPM_DIV   = 5'd10;
    localparam logic [STEP_W-1:0] A_E_ACCEPT  = 5'd11;
    localparam logic [STEP_W-1:0] A_E_CLEAR   = 5'd12;
    localparam logic [STEP_W-1:0] A_E_ARMED   = 5'd13;
    localparam logic [STEP_W-1:0] A_E_TIMEOUT = 5'd14;
    localparam logic [STEP_W-1:0] A_E_FAST    = 5'd15;
    localparam logic [STEP_W-1:0] A_E_OUTLIER = 5'd16;

    // The microprogram. A step jumps to its target when its condition holds
    // and falls through to the next step otherwise.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        w = '0;
        w.op = OP_NOP;
        w.cond = C_NEVER;
        case (addr)
            A_FETCH:     begin w.cond = C_NO_REQ;    w.target = A_FETCH;     end
            A_CLASSIFY:  begin w.op = OP_GAP; w.cond = C_CLEAR; w.target = A_E_CLEAR; end
            A_ARMCHK:    begin w.cond = C_NOT_ARMED; w.target = A_E_ARMED;   end
            A_TOUTCHK:   begin w.cond = C_TIMEOUT;   w.target = A_E_TIMEOUT; end
            A_FASTCHK:   begin w.cond = C_FAST;      w.target = A_E_FAST;    end
            A_OUTCHK:    begin w.cond = C_OUTLIER;   w.target = A_E_OUTLIER; end
            A_MEAN_LD:   begin w.op = OP_DIV_MEAN; end
            A_MEAN_DIV:  begin w.op = OP_DIV_STEP; w.cond = C_MORE; w.target = A_MEAN_DIV; end
            A_MEAN_UPD:  begin w.op = OP_MEAN_UPD; end
            A_BPM_LD:
            begin
                w.op = OP_DIV_BPM;
                w.cond = C_MEAN_ZERO;
                w.target = A_E_ACCEPT;
            end
            A_BPM_DIV:   begin w.op = OP_DIV_STEP; w.cond = C_MORE; w.target = A_BPM_DIV; end
            A_E_ACCEPT:
            begin
                w.op = OP_EMIT; w.cond = C_ALWAYS; w.target = A_FETCH; w.wait_out = 1'b1;
                w.valid = 1'b1; w.status = ST_ACCEPT;
            end
            A_E_CLEAR:
            begin
                w.op = OP_EMIT; w.cond = C_ALWAYS; w.target = A_FETCH; w.wait_out = 1'b1;
                w.status = ST_CLEAR; w.clr_mean = 1'b1; w.clr_armed = 1'b1;
            end
            A_E_ARMED:
            begin
                w.op = OP_EMIT; w.cond = C_ALWAYS; w.target = A_FETCH; w.wait_out = 1'b1;
                w.status = ST_ARMED; w.set_last = 1'b1; w.clr_mean = 1'b1;
                w.set_armed = 1'b1;
            end
            A_E_TIMEOUT:
            begin
                w.op = OP_EMIT; w.cond = C_ALWAYS; w.target = A_FETCH; w.wait_out = 1'b1;
                w.status = ST_TIMEOUT; w.set_last = 1'b1; w.clr_mean = 1'b1;
            end
            A_E_FAST:
            begin
                w.op = OP_EMIT; w.cond = C_ALWAYS; w.target = A_FETCH; w.wait_out = 1'b1;
                w.status = ST_FAST;
            end
            A_E_OUTLIER:
            begin
                w.op = OP_EMIT; w.cond = C_ALWAYS; w.target = A_FETCH; w.wait_out = 1'b1;
                w.status = ST_OUTLIER; w.set_last = 1'b1;
            end
            default:     begin w.cond = C_ALWAYS; w.target = A_FETCH; end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/tte_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle while ctrl.step is high.
// Depends on tte_pkg for the control struct.
module tte_divider
    import tte_pkg::*;
#(
    parameter int DW = 42,
    parameter int MW = 40,
    parameter int IW = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  div_ctrl_t     ctrl,
    input  logic [DW-1:0] dividend,
    input  logic [MW-1:0] divisor,
    input  logic [IW-1:0] iters,
    output logic [DW-1:0] quotient,
    output logic          more
);

    logic [DW-1:0] acc_reg, acc_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [MW-1:0] div_reg, div_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic [MW:0]   trial;
    logic [MW:0]   trial_diff;
    logic          fits;

    // The dividend enters at the top of acc; quotient bits shift in below.
    always_comb
    begin
        trial      = {rem_reg, acc_reg[DW-1]};
        trial_diff = trial - {1'b0, div_reg};
        fits       = trial >= {1'b0, div_reg};
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        iter_next  = iter_reg;
        if (ctrl.load)
        begin
            acc_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            iter_next = iters;
        end
        else if (ctrl.step)
        begin
            acc_next  = {acc_reg[DW-2:0], fits};
            rem_next  = fits ? trial_diff[MW-1:0] : trial[MW-1:0];
            iter_next = iter_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else
        begin
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient = acc_reg;
    assign more     = iter_reg > IW'(1);

endmodule

// ===== rtl/tap_tempo_estimator.sv =====
// Tap tempo estimator top level: microcode sequencer, datapath and state.
// Depends on tte_pkg, tte_divider and tap_tempo_estimator_assert.svh.
//
// Usage: in_data carries one request, a tap with its microsecond stamp or a
// clear. in_ready is high only while the sequencer sits at its fetch step, so
// one request is worked on at a time. Every request gives exactly one result
// on out_data, held in an output register until out_valid meets out_ready.
// An accepted tap runs the shared divider twice, once for the mean update
// (TIME_WIDTH+8 quotient bits) and once for the tempo (max(42, TIME_WIDTH+8)
// quotient bits), or only once when the new mean is zero and the tempo
// divide is skipped. in_ready rises with out_valid. A new request may be
// taken while the previous result still waits; the sequencer stalls only
// at its output step when the output register is full and out_ready is
// low. cfg_wr_en writes timeout_us (index 0) or min_gap_us (index 1) at
// once; the user must write it only while the block is idle, which the
// block itself does not enforce.
// Reset clears the armed flag, last tap time, mean, tap count and the output
// valid flag, and loads the register defaults; the block is ready at once.
`include "tap_tempo_estimator_assert.svh"

module tap_tempo_estimator
    import tte_pkg::*;
#(
    parameter int MAX_TAPS   = 8,
    parameter int TIME_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int TW = TIME_WIDTH;
    localparam int MW = TW + FRAC_BITS;
    localparam int DW = (MW > 42) ? MW : 42;
    localparam int CW = (TW > CFG_W) ? TW : CFG_W;
    localparam int IW = $clog2(DW + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              armed_reg, armed_next;
    logic [TW-1:0]     last_reg, last_next;
    logic [MW-1:0]     mean_reg, mean_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CFG_W-1:0]  timeout_reg, timeout_next;
    logic [CFG_W-1:0]  min_gap_reg, min_gap_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic [TW-1:0]     now_reg, now_next;
    logic              clear_reg, clear_next;
    logic [TW-1:0]     gap_reg, gap_next;
    logic              up_reg, up_next;

    ucode_t            uw;
    logic              stall;
    logic              cond_true;
    logic [MW-1:0]     g;
    logic              outlier;
    logic [CNT_W-1:0]  n_taps;
    logic [MW-1:0]     mean_diff;
    logic [15:0]       bpm_sat;
    div_ctrl_t         div_ctrl;
    logic [DW-1:0]     div_dividend;
    logic [MW-1:0]     div_divisor;
    logic [IW-1:0]     div_iters;
    logic [DW-1:0]     div_quot;
    logic              div_more;

    tte_divider #(
        .DW (DW),
        .MW (MW),
        .IW (IW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .quotient (div_quot),
        .more     (div_more)
    );

    assign uw       = ucode_rom(step_reg);
    assign in_ready = (step_reg == A_FETCH);

    // Exact outlier test on the gap with eight fraction bits.
    assign g       = {gap_reg, {FRAC_BITS{1'b0}}};
    assign outlier = (mean_reg != '0) &&
                     (({g, 1'b0} < {1'b0, mean_reg}) || ({1'b0, g} > {mean_reg, 1'b0}));
    assign n_taps  = (cnt_reg < CNT_W'(MAX_TAPS)) ? cnt_reg + 1'b1 : CNT_W'(MAX_TAPS);
    assign mean_diff = (g >= mean_reg) ? g - mean_reg : mean_reg - g;
    assign bpm_sat = (|div_quot[DW-1:16]) ? 16'hFFFF : div_quot[15:0];

    always_comb
    begin
        stall = uw.wait_out && out_valid_reg && !out_ready;
        case (uw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_REQ:    cond_true = !in_valid;
            C_CLEAR:     cond_true = clear_reg;
            C_NOT_ARMED: cond_true = !armed_reg;
            C_TIMEOUT:   cond_true = CW'(gap_reg) > CW'(timeout_reg);
            C_FAST:      cond_true = CW'(gap_reg) < CW'(min_gap_reg);
            C_OUTLIER:   cond_true = outlier;
            C_MORE:      cond_true = div_more;
            C_MEAN_ZERO: cond_true = (mean_reg == '0);
            default:     cond_true = 1'b0;
        endcase

        if (stall)
            step_next = step_reg;
        else if (cond_true)
            step_next = uw.target;
        else
            step_next = step_reg + 1'b1;

        armed_next     = armed_reg;
        last_next      = last_reg;
        mean_next      = mean_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        clear_next     = clear_reg;
        gap_next       = gap_reg;
        up_next        = up_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        timeout_next   = timeout_reg;
        min_gap_next   = min_gap_reg;
        div_ctrl       = '0;
        div_dividend   = DW'(mean_diff) << (DW - MW);
        div_divisor    = MW'(n_taps);
        div_iters      = IW'(MW);

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_next = cfg_data;
                CFG_MIN_GAP: min_gap_next = cfg_data;
                default:     timeout_next = timeout_reg;
            endcase
        end

        if (in_valid && in_ready)
        begin
            now_next   = TW'(in_data.tap_time_us);
            clear_next = in_data.operation;
        end

        case (uw.op)
            OP_NOP:
            begin
                div_ctrl = '0;
            end
            OP_GAP:
            begin
                gap_next = now_reg - last_reg;
            end
            OP_DIV_MEAN:
            begin
                div_ctrl.load = 1'b1;
                up_next       = (g >= mean_reg);
                cnt_next      = n_taps;
            end
            OP_DIV_STEP:
            begin
                div_ctrl.step = 1'b1;
            end
            OP_MEAN_UPD:
            begin
                mean_next = up_reg ? mean_reg + div_quot[MW-1:0]
                                   : mean_reg - div_quot[MW-1:0];
                last_next = now_reg;
            end
            OP_DIV_BPM:
            begin
                // A zero mean loads all ones so the tempo saturates.
                div_ctrl.load = 1'b1;
                div_divisor   = mean_reg;
                div_iters     = IW'(DW);
                div_dividend  = (mean_reg == '0) ? '1
                              : DW'(CENTI_MINUTE_Q8) + DW'(mean_reg >> 1);
            end
            OP_EMIT:
            begin
                if (!stall)
                begin
                    out_valid_next      = 1'b1;
                    out_next.bpm_valid  = uw.valid;
                    out_next.bpm_centi  = uw.valid ? bpm_sat : 16'd0;
                    out_next.tap_status = uw.status;
                    if (uw.set_last)
                        last_next = now_reg;
                    if (uw.clr_mean)
                    begin
                        mean_next = '0;
                        cnt_next  = '0;
                    end
                    if (uw.set_armed)
                        armed_next = 1'b1;
                    if (uw.clr_armed)
                        armed_next = 1'b0;
                end
            end
            default:
            begin
                div_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= A_FETCH;
            armed_reg     <= 1'b0;
            last_reg      <= '0;
            mean_reg      <= '0;
            cnt_reg       <= '0;
            timeout_reg   <= CFG_W'(2000000);
            min_gap_reg   <= CFG_W'(200000);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            armed_reg     <= armed_next;
            last_reg      <= last_next;
            mean_reg      <= mean_next;
            cnt_reg       <= cnt_next;
            timeout_reg   <= timeout_next;
            min_gap_reg   <= min_gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        now_reg   <= now_next;
        clear_reg <= clear_next;
        gap_reg   <= gap_next;
        up_reg    <= up_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `TTE_ASSERT_NOW(a_count_capped, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_TAPS),
        "tap count above its cap")
    `TTE_ASSERT_NOW(a_mean_needs_armed, clk, rst_n, mean_reg != '0, armed_reg,
        "nonzero mean while not armed")
    `TTE_ASSERT_NOW(a_bpm_only_accept, clk, rst_n, out_valid_reg && out_reg.bpm_valid,
        out_reg.tap_status == ST_ACCEPT, "tempo given without an accepted tap")
    `TTE_ASSERT_NEXT(a_fetch_to_classify, clk, rst_n, in_valid && in_ready,
        step_reg == A_CLASSIFY, "request accepted but sequencer did not advance")

endmodule

// ===== tb/tap_tempo_checker.sv =====
`timescale 1ns / 1ps
// Checker for the tap tempo estimator: watches the request and result channels and the
// configuration port, predicts each result and compares. Depends on tte_pkg.
module tap_tempo_checker
    import tte_pkg::*;
#(
    parameter int MAX_TAPS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fault_count,
    output int                   pending_count
);

    logic [31:0] timeout_us;
    logic [31:0] min_gap_us;
    logic        armed;
    logic [31:0] last_tap;
    logic [39:0] mean_q8;
    logic [3:0]  taps_seen;

    out_item_t   expected_results[$];

    function automatic logic [15:0] centi_bpm(input logic [63:0] mean);
        logic [63:0] quot;
        if (mean == 64'd0)
        begin
            return 16'hFFFF;
        end
        quot = (CENTI_MINUTE_Q8 + (mean >> 1)) / mean;
        return (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
    endfunction

    task automatic advance_tempo(input in_item_t req, output out_item_t res);
        logic [31:0] gap;
        logic [63:0] gap_q8;
        logic [63:0] mean;
        logic [63:0] weight;
        res = '0;
        if (req.operation)
        begin
            armed = 1'b0;
            mean_q8 = '0;
            taps_seen = '0;
            res.tap_status = ST_CLEAR;
        end
        else if (!armed)
        begin
            armed = 1'b1;
            last_tap = req.tap_time_us;
            mean_q8 = '0;
            taps_seen = '0;
            res.tap_status = ST_ARMED;
        end
        else
        begin
            gap = req.tap_time_us - last_tap;
            gap_q8 = {32'd0, gap} << FRAC_BITS;
            mean = {24'd0, mean_q8};
            if (gap > timeout_us)
            begin
                last_tap = req.tap_time_us;
                mean_q8 = '0;
                taps_seen = '0;
                res.tap_status = ST_TIMEOUT;
            end
            else if (gap < min_gap_us)
            begin
                res.tap_status = ST_FAST;
            end
            else if (mean != 64'd0 && ((gap_q8 << 1) < mean || gap_q8 > (mean << 1)))
            begin
                last_tap = req.tap_time_us;
                res.tap_status = ST_OUTLIER;
            end
            else
            begin
                weight = (taps_seen < MAX_TAPS) ? 64'(taps_seen) + 64'd1 : 64'(MAX_TAPS);
                if (gap_q8 >= mean)
                begin
                    mean = mean + (gap_q8 - mean) / weight;
                end
                else
                begin
                    mean = mean - (mean - gap_q8) / weight;
                end
                mean_q8 = mean[39:0];
                taps_seen = weight[3:0];
                last_tap = req.tap_time_us;
                res.bpm_valid = 1'b1;
                res.bpm_centi = centi_bpm(mean);
                res.tap_status = ST_ACCEPT;
            end
        end
    endtask

    // Only the first ten faults are described; the rest are counted.
    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        out_item_t fresh;
        if (!rst_n)
        begin
            timeout_us = 32'd2000000;
            min_gap_us = 32'd200000;
            armed = 1'b0;
            last_tap = '0;
            mean_q8 = '0;
            taps_seen = '0;
            expected_results.delete();
            fault_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_us = cfg_data;
                    CFG_MIN_GAP: min_gap_us = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    note_fault($sformatf("unexpected result valid=%0d bpm=%0d status=%0d",
                        out_data.bpm_valid, out_data.bpm_centi, out_data.tap_status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.bpm_valid !== want.bpm_valid ||
                        out_data.bpm_centi !== want.bpm_centi ||
                        out_data.tap_status !== want.tap_status)
                    begin
                        note_fault($sformatf({"mismatch: expected valid=%0d bpm=%0d ",
                            "status=%0d, got valid=%0d bpm=%0d status=%0d"},
                            want.bpm_valid, want.bpm_centi, want.tap_status,
                            out_data.bpm_valid, out_data.bpm_centi, out_data.tap_status));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                advance_tempo(in_data, fresh);
                expected_results.push_back(fresh);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the tap tempo estimator testbench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on tte_pkg, tap_tempo_estimator and tap_tempo_checker.
module testbench;
    import tte_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 120;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TIMEOUT;
    logic [CFG_W-1:0]     cfg_data = '0;

    int          fault_count;
    int          pending_count;
    int          quiet_cycles = 0;
    int          requests_sent = 0;
    int          results_taken = 0;
    logic        sender_brisk = 1'b0;
    logic        receiver_brisk = 1'b0;
    logic [31:0] stamp_now = '0;
    logic [31:0] cur_timeout = 32'd2000000;
    logic [31:0] cur_min_gap = 32'd200000;

    tap_tempo_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tap_tempo_checker monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fault_count   (fault_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic offer(input logic op, input logic [31:0] stamp);
        int gap;
        gap = sender_brisk ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {op, stamp};
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        requests_sent++;
        if (requests_sent % 40 == 0)
        begin
            sender_brisk = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic tap_after(input logic [31:0] delta);
        stamp_now = stamp_now + delta;
        offer(1'b0, stamp_now);
    endtask

    // Stops offering until every predicted result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_config(input logic [31:0] timeout, input logic [31:0] min_gap);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= timeout;
        @(negedge clk);
        cfg_index <= CFG_MIN_GAP;
        cfg_data <= min_gap;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_timeout = timeout;
        cur_min_gap = min_gap;
    endtask

    function automatic logic [31:0] pick_period();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = cur_min_gap;
        hi = cur_timeout;
        if (lo > hi)
        begin
            return $urandom;
        end
        // Keep half of the runs at human tap rates when the window is very wide.
        if (hi - lo > 32'd4000000 && $urandom_range(0, 1) == 0)
        begin
            hi = lo + 32'd4000000;
        end
        return $urandom_range(hi, lo);
    endfunction

    // Mostly steady tap runs with jitter, some of them spoiled, plus noise.
    task automatic random_phase(input int count);
        int          done;
        int          run_len;
        int          kind;
        logic [31:0] period;
        logic [31:0] jitter;
        logic [31:0] delta;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    offer(1'b1, $urandom);
                    done++;
                end
                period = pick_period();
                jitter = period >> 4;
                run_len = $urandom_range(3, 12);
                for (int i = 0; i < run_len; i++)
                begin
                    kind = $urandom_range(0, 11);
                    if (kind == 0)
                    begin
                        delta = period * 3;
                    end
                    else if (kind == 1)
                    begin
                        delta = period / 3;
                    end
                    else if (kind == 2)
                    begin
                        delta = $urandom_range(cur_min_gap, 0);
                    end
                    else
                    begin
                        delta = period - jitter + $urandom_range(2 * jitter, 0);
                    end
                    tap_after(delta);
                    done++;
                end
            end
            else
            begin
                kind = $urandom_range(0, 3);
                case (kind)
                    0: offer(1'b1, $urandom);
                    1:
                    begin
                        stamp_now = $urandom;
                        offer(1'b0, stamp_now);
                    end
                    2: tap_after(cur_timeout + $urandom_range(1000, 1));
                    default: tap_after($urandom_range(cur_min_gap, 0));
                endcase
                done++;
            end
        end
        settle();
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default registers: arming, acceptance, too fast, short-gap outliers,
        // timeout restart, the exact half-mean boundary and a clear.
        offer(1'b0, 32'd0);
        tap_after(32'd500000);
        tap_after(32'd500000);
        tap_after(32'd100000);
        tap_after(32'd2000000);
        tap_after(32'd2000001);
        tap_after(32'd600000);
        tap_after(32'd250000);
        tap_after(32'd300000);
        tap_after(32'd200000);
        tap_after(32'd199999);
        offer(1'b1, 32'hFFFF_FFFF);
        offer(1'b1, 32'd0);
        // Stamps that wrap past the top of the counter.
        stamp_now = 32'hFFFF_FFF0;
        offer(1'b0, stamp_now);
        tap_after(32'd500000);
        tap_after(32'd520000);
        settle();

        // Widest window: zero gaps give a zero mean, full-range gaps pass.
        set_config(32'hFFFF_FFFF, 32'd0);
        offer(1'b1, 32'd0);
        offer(1'b0, 32'd0);
        offer(1'b0, 32'd0);
        offer(1'b0, 32'd0);
        offer(1'b0, 32'hFFFF_FFFF);
        offer(1'b1, 32'd0);
        offer(1'b0, 32'hFFFF_FFFF);
        offer(1'b0, 32'hFFFF_FFFE);
        offer(1'b0, 32'd50000);
        settle();

        set_config(32'd2000000, 32'd200000);
        random_phase(250);
        set_config(32'd1, 32'd0);
        random_phase(100);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(100);
        set_config(32'hFFFF_FFFF, 32'd0);
        random_phase(200);
        // Short minimum gap so the tempo saturates often.
        set_config(32'd300000, 32'd20000);
        random_phase(200);
        for (int p = 0; p < 4; p++)
        begin
            cur_min_gap = $urandom_range(300000, 0);
            set_config($urandom_range(4000000, cur_min_gap + 1000), cur_min_gap);
            random_phase(190);
        end
        set_config($urandom, $urandom);
        random_phase(60);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (fault_count == 0 && pending_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Result side: random back-pressure, and twice a long hold-off while
    // requests keep coming so that the block fills and stalls its input.
    initial
    begin : drain_results
        int hold;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            hold = receiver_brisk ? 0 : $urandom_range(0, 14);
            if (results_taken == 300 || results_taken == 1000)
            begin
                hold = 400;
            end
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            results_taken++;
            if (results_taken % 40 == 0)
            begin
                receiver_brisk = ($urandom_range(0, 3) == 0);
            end
            @(negedge clk);
        end
    end

endmodule
